>>> sv/ndts_pkg.sv
package ndts_pkg;

  localparam int AXES          = 4;
  localparam int AX_W          = $clog2(AXES);
  localparam int SIZE_W        = 9;
  localparam int COORD_W       = 8;
  localparam int ORDER_W       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 9;
  localparam int DATA_W        = 64;
  localparam int DEST_W        = 32;
  localparam int CNT_W         = $clog2(AXES + 1);
  localparam int NUM_SIZE_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd4;
  localparam logic [SIZE_W-1:0]    SIZE_RESET     = 9'd1;
  localparam logic [SIZE_W-1:0]    SIZE_MAX       = 9'd256;
  localparam logic [ORDER_W-1:0]   ORDER_RESET    = 8'd228;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_STRIDE,
    ST_OFFSET,
    ST_SUM,
    ST_RUN
  } ndts_state_t;

  typedef struct packed {
    logic            clr_stride;
    logic            ld_stride;
    logic [AX_W-1:0] ld_axis;
    logic            mul_off;
    logic            sum_step;
    logic            step;
  } ndts_ctl_t;

  // zero acts as one, anything above 256 acts as 256
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_RESET;
    end else if (s > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

>>> sv/ndts_cell.sv
module ndts_cell #(
  parameter int IDX        = 0,
  parameter int INDEX_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ndts_pkg::ndts_ctl_t       ctl,
  input  logic [INDEX_BITS-1:0]     prod,
  input  logic [ndts_pkg::SIZE_W-1:0] size,
  input  logic                      carry_in,
  input  logic [INDEX_BITS-1:0]     d_in,
  input  logic [INDEX_BITS-1:0]     w_in,
  input  logic [INDEX_BITS-1:0]     off_in,
  output logic                      carry_out,
  output logic [INDEX_BITS-1:0]     d_out,
  output logic [INDEX_BITS-1:0]     w_out,
  output logic [INDEX_BITS-1:0]     off_out
);
  import ndts_pkg::*;

  logic [COORD_W-1:0]          coord_r, coord_nxt;
  logic [INDEX_BITS-1:0]       stride_r;
  logic [INDEX_BITS-1:0]       off_r;
  // sum of coord*stride over all faster axes
  logic [INDEX_BITS-1:0]       w_r;
  logic [SIZE_W-1:0]           coord_p1;
  logic                        fin;
  logic                        inc;
  logic [INDEX_BITS+COORD_W-1:0] mul_full;

  assign coord_p1  = {1'b0, coord_r} + SIZE_W'(1);
  assign fin       = (coord_p1 >= size);
  assign carry_out = carry_in & fin;
  assign inc       = carry_in & ~fin;
  assign d_out     = inc ? (stride_r - w_r) : d_in;
  assign w_out     = w_r;
  assign off_out   = off_r;
  assign mul_full  = {{INDEX_BITS{1'b0}}, coord_r} * {{COORD_W{1'b0}}, stride_r};
  assign coord_nxt = fin ? '0 : coord_p1[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else if (ctl.step && carry_in) begin
      coord_r <= coord_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_stride) begin
      stride_r <= '0;
    end else if (ctl.ld_stride && (ctl.ld_axis == AX_W'(IDX))) begin
      stride_r <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_off) begin
      off_r <= mul_full[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_step) begin
      w_r <= w_in + off_in;
    end else if (ctl.step) begin
      // faster axes all wrap; slower ones shift by the incremented axis's delta
      w_r <= carry_in ? '0 : (w_r + d_in);
    end
  end

endmodule

>>> sv/ndim_transpose_scatter.sv
// an accepted item is registered and shows on the output in the next cycle
// throughput: one item per cycle while the output is not stalled and no pass runs, set
//   by the combinational odometer step through the row of axis cells
// reset and every config write start a pass (clear, 4 stride products,
//   offset multiply, 5 suffix-sum hops) during which in_ready is low
// synchronous active-low reset clears coordinates, destination, config registers and out_valid
module ndim_transpose_scatter #(
  parameter int INDEX_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ndts_pkg::DATA_W-1:0]      in_element_bits,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ndts_pkg::DEST_W-1:0]      out_dest_index,
  output logic [ndts_pkg::DATA_W-1:0]      out_bits,
  output logic                             out_last_element,
  input  logic                             cfg_we,
  input  logic [ndts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ndts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ndts_pkg::*;

  ndts_state_t             state_r, state_nxt;
  ndts_ctl_t               ctl;
  logic [CNT_W-1:0]        cnt_r;
  logic [INDEX_BITS-1:0]   prod_r;
  logic [INDEX_BITS+SIZE_W-1:0] prod_full;
  logic [SIZE_W-1:0]       size_r [NUM_SIZE_REGS];
  logic [SIZE_W-1:0]       eff [AXES];
  logic [ORDER_W-1:0]      axis_order_r;
  logic [AX_W-1:0]         cur_ax;
  logic [INDEX_BITS-1:0]   dest_r;
  logic [INDEX_BITS-1:0]   total_r;
  logic [INDEX_BITS+DEST_W-1:0] dest_ext;
  logic                    accept;
  logic                    out_valid_r;
  logic [DEST_W-1:0]       out_dest_r;
  logic [DATA_W-1:0]       out_bits_r;
  logic                    out_last_r;

  logic                    carry [AXES+1];
  logic [INDEX_BITS-1:0]   dch   [AXES+1];
  logic [INDEX_BITS-1:0]   wv    [AXES+1];
  logic [INDEX_BITS-1:0]   ov    [AXES+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
        size_r[i] <= SIZE_RESET;
      end
      axis_order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(NUM_SIZE_REGS)) begin
        size_r[cfg_index[AX_W-1:0]] <= cfg_data;
      end else if (cfg_index == REG_AXIS_ORDER) begin
        axis_order_r <= cfg_data[ORDER_W-1:0];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      eff[a] = eff_size(size_r[a]);
    end
  end

  assign cur_ax    = axis_order_r[{cnt_r[AX_W-1:0], 1'b0} +: AX_W];
  assign prod_full = {{SIZE_W{1'b0}}, prod_r} * {{INDEX_BITS{1'b0}}, eff[cur_ax]};

  assign in_ready = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:    state_nxt = ST_STRIDE;
      ST_STRIDE: if (cnt_r == '0) state_nxt = ST_OFFSET;
      ST_OFFSET: state_nxt = ST_SUM;
      ST_SUM:    if (cnt_r == '0) state_nxt = ST_RUN;
      ST_RUN:    state_nxt = ST_RUN;
      default:   state_nxt = ST_CLR;
    endcase
    if (cfg_we) begin
      state_nxt = ST_CLR;
    end
  end

  // cell controls
  always_comb begin
    ctl         = '0;
    ctl.ld_axis = cur_ax;
    case (state_r)
      ST_CLR:    ctl.clr_stride = 1'b1;
      ST_STRIDE: ctl.ld_stride  = 1'b1;
      ST_OFFSET: ctl.mul_off    = 1'b1;
      ST_SUM:    ctl.sum_step   = 1'b1;
      ST_RUN:    ctl.step       = accept;
      default:   ctl            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pass counter and running stride product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      prod_r <= '0;
    end else begin
      case (state_r)
        ST_CLR: begin
          cnt_r  <= CNT_W'(AXES - 1);
          prod_r <= INDEX_BITS'(1);
        end
        ST_STRIDE: begin
          prod_r <= prod_full[INDEX_BITS-1:0];
          if (cnt_r == '0) begin
            cnt_r <= CNT_W'(AXES);
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_SUM: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // fastest end of the chain
  assign carry[AXES] = 1'b1;
  assign dch[AXES]   = '0;
  assign wv[AXES]    = '0;
  assign ov[AXES]    = '0;

  for (genvar a = 0; a < AXES; a++) begin : g_cell
    ndts_cell #(
      .IDX        (a),
      .INDEX_BITS (INDEX_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prod      (prod_r),
      .size      (eff[a]),
      .carry_in  (carry[a+1]),
      .d_in      (dch[a+1]),
      .w_in      (wv[a+1]),
      .off_in    (ov[a+1]),
      .carry_out (carry[a]),
      .d_out     (dch[a]),
      .w_out     (wv[a]),
      .off_out   (ov[a])
    );
  end

  // running destination and total offset of all axes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= '0;
    end else if (ctl.step) begin
      dest_r <= carry[0] ? (dest_r - total_r) : (dest_r + dch[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_step) begin
      total_r <= wv[0] + ov[0];
    end else if (ctl.step) begin
      total_r <= carry[0] ? '0 : (total_r + dch[0]);
    end
  end

  assign dest_ext = {{DEST_W{1'b0}}, dest_r};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_dest_r <= dest_ext[DEST_W-1:0];
      out_bits_r <= in_element_bits;
      out_last_r <= carry[0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_index   = out_dest_r;
  assign out_bits         = out_bits_r;
  assign out_last_element = out_last_r;

endmodule

>>> sv/ndts_checker.sv
module ndts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ndts_pkg::DEST_W-1:0]     out_dest_index,
  input logic [ndts_pkg::DATA_W-1:0]     out_bits,
  input logic                            out_last_element,
  input logic                            cfg_we
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_index)
      && $stable(out_bits) && $stable(out_last_element))
    else $error("stalled result changed");

  // an accepted item is presented on the next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item not presented");

  // a config write starts the recompute pass, which blocks input
  a_cfg_blocks: assert property (@(posedge clk)
    cfg_we |=> !in_ready)
    else $error("input taken right after config write");

  // reset empties the output stage and blocks input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output or input live after reset");

endmodule

bind ndim_transpose_scatter ndts_checker u_ndts_checker (.*);
